[rtl/evm_pkg.sv]
// ----------------------------------------------------------------------------
// evm_pkg
// Shared types, widths and helpers for the Y-X-Z Euler view matrix pipeline.
// ----------------------------------------------------------------------------
package evm_pkg;

    localparam int ANGLE_W = 16;
    localparam int POS_W   = 32;
    localparam int AXIS_W  = 16;
    localparam int SHIFT_W = 32;
    localparam int SC_W    = 17;
    localparam int VW      = 48;

    localparam int SINE_LAT  = 4;
    localparam int AXIS_LAT  = 3;
    localparam int XLATE_LAT = 2;
    localparam int POS_DLY   = 1 + SINE_LAT + AXIS_LAT;
    localparam int LATENCY   = POS_DLY + XLATE_LAT;

    localparam logic [18:0] TURN_SCALE = 19'd166886;
    localparam logic [14:0] QUARTER    = 15'd16384;
    localparam logic [14:0] POLY_A     = 15'd25736;
    localparam logic [13:0] POLY_B     = 14'd10512;
    localparam logic [10:0] POLY_C     = 11'd1160;

    typedef logic signed [SC_W-1:0]   t_sc;
    typedef logic signed [AXIS_W-1:0] t_axis;
    typedef logic signed [POS_W-1:0]  t_pos;

    typedef struct packed {
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_z;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
        logic signed [ANGLE_W-1:0] roll_angle;
    } t_pose;

    typedef struct packed {
        logic signed [AXIS_W-1:0]  right_x;
        logic signed [AXIS_W-1:0]  right_y;
        logic signed [AXIS_W-1:0]  right_z;
        logic signed [AXIS_W-1:0]  upward_x;
        logic signed [AXIS_W-1:0]  upward_y;
        logic signed [AXIS_W-1:0]  upward_z;
        logic signed [AXIS_W-1:0]  forward_x;
        logic signed [AXIS_W-1:0]  forward_y;
        logic signed [AXIS_W-1:0]  forward_z;
        logic signed [SHIFT_W-1:0] shift_right;
        logic signed [SHIFT_W-1:0] shift_upward;
        logic signed [SHIFT_W-1:0] shift_forward;
    } t_view;

    function automatic t_axis axis_clamp(input logic signed [19:0] v);
        if (v > 20'sd16384) begin
            return t_axis'(16384);
        end else if (v < -20'sd16384) begin
            return -t_axis'(16384);
        end
        return v[AXIS_W-1:0];
    endfunction

    // round a value with 42 fraction bits to Q1.14
    function automatic t_axis axis_round(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] t;
        t = v + VW'(134217728);
        return axis_clamp($signed(t[47:28]));
    endfunction

endpackage

[rtl/evm_sine.sv]
// ----------------------------------------------------------------------------
// evm_sine
// Four-stage quarter-wave polynomial sine of a 16-bit phase, Q1.14 result.
// ----------------------------------------------------------------------------
module evm_sine import evm_pkg::*; (
    input  logic        i_clk,
    input  logic [15:0] i_phase,
    output t_sc         o_sin
);
    logic [14:0] qq;
    logic [29:0] p_qq;
    logic [24:0] p_c;
    logic [27:0] p_zt;
    logic [29:0] p_qt;
    logic [15:0] s;

    logic [14:0] r_q1, r_z2_1, r_q2, r_z2_2, r_q3;
    logic [13:0] r_t1;
    logic [14:0] r_t2;
    logic        r_neg1, r_neg2, r_neg3;
    t_sc         r_sin;

    always_comb begin
        qq = i_phase[14] ? (QUARTER - {1'b0, i_phase[13:0]}) : {1'b0, i_phase[13:0]};
        p_qq = qq * qq;
        p_c  = POLY_C * r_z2_1;
        p_zt = r_z2_2 * r_t1;
        p_qt = r_q3 * r_t2;
        s    = p_qt[29:14];
    end

    always_ff @(posedge i_clk) begin
        r_q1   <= qq;
        r_neg1 <= i_phase[15];
        r_z2_1 <= p_qq[28:14];

        r_q2   <= r_q1;
        r_neg2 <= r_neg1;
        r_z2_2 <= r_z2_1;
        r_t1   <= POLY_B - {3'b000, p_c[24:14]};

        r_q3   <= r_q2;
        r_neg3 <= r_neg2;
        r_t2   <= POLY_A - {1'b0, p_zt[27:14]};

        r_sin  <= r_neg3 ? -$signed({1'b0, s}) : $signed({1'b0, s});
    end

    assign o_sin = r_sin;

endmodule

[rtl/evm_axes.sv]
// ----------------------------------------------------------------------------
// evm_axes
// Three-stage basis axis builder: pair products, triple products, round.
// ----------------------------------------------------------------------------
module evm_axes import evm_pkg::*; (
    input  logic  i_clk,
    input  t_sc   i_s1,
    input  t_sc   i_c1,
    input  t_sc   i_s2,
    input  t_sc   i_c2,
    input  t_sc   i_s3,
    input  t_sc   i_c3,
    output t_axis o_ax [9]
);
    logic signed [33:0] r_c1c3, r_s1s2, r_c1s2, r_c3s1, r_c1s3;
    logic signed [33:0] r_s1s3, r_c2s3, r_c2c3, r_c2s1, r_c1c2;
    t_sc                r_s2a, r_s3a, r_c3a, r_s2b;
    logic signed [33:0] r_b_c1c3, r_b_c3s1, r_b_c1s3, r_b_s1s3;
    logic signed [33:0] r_b_c2s3, r_b_c2c3, r_b_c2s1, r_b_c1c2;
    logic signed [50:0] r_m0, r_m2, r_m3, r_m5;
    t_axis              r_ax [9];

    function automatic logic signed [VW-1:0] up14(input logic signed [33:0] x);
        return VW'(x) <<< 14;
    endfunction

    function automatic logic signed [VW-1:0] lo(input logic signed [50:0] x);
        return $signed(x[VW-1:0]);
    endfunction

    always_ff @(posedge i_clk) begin
        r_c1c3 <= i_c1 * i_c3;
        r_s1s2 <= i_s1 * i_s2;
        r_c1s2 <= i_c1 * i_s2;
        r_c3s1 <= i_c3 * i_s1;
        r_c1s3 <= i_c1 * i_s3;
        r_s1s3 <= i_s1 * i_s3;
        r_c2s3 <= i_c2 * i_s3;
        r_c2c3 <= i_c2 * i_c3;
        r_c2s1 <= i_c2 * i_s1;
        r_c1c2 <= i_c1 * i_c2;
        r_s2a  <= i_s2;
        r_s3a  <= i_s3;
        r_c3a  <= i_c3;

        r_m0 <= r_s1s2 * r_s3a;
        r_m2 <= r_c1s2 * r_s3a;
        r_m3 <= r_s1s2 * r_c3a;
        r_m5 <= r_c1s2 * r_c3a;
        r_b_c1c3 <= r_c1c3;
        r_b_c3s1 <= r_c3s1;
        r_b_c1s3 <= r_c1s3;
        r_b_s1s3 <= r_s1s3;
        r_b_c2s3 <= r_c2s3;
        r_b_c2c3 <= r_c2c3;
        r_b_c2s1 <= r_c2s1;
        r_b_c1c2 <= r_c1c2;
        r_s2b    <= r_s2a;

        r_ax[0] <= axis_round(up14(r_b_c1c3) + lo(r_m0));
        r_ax[1] <= axis_round(up14(r_b_c2s3));
        r_ax[2] <= axis_round(lo(r_m2) - up14(r_b_c3s1));
        r_ax[3] <= axis_round(lo(r_m3) - up14(r_b_c1s3));
        r_ax[4] <= axis_round(up14(r_b_c2c3));
        r_ax[5] <= axis_round(lo(r_m5) + up14(r_b_s1s3));
        r_ax[6] <= axis_round(up14(r_b_c2s1));
        r_ax[7] <= axis_clamp(-(20'(r_s2b)));
        r_ax[8] <= axis_round(up14(r_b_c1c2));
    end

    assign o_ax = r_ax;

endmodule

[rtl/evm_xlate.sv]
// ----------------------------------------------------------------------------
// evm_xlate
// Two-stage negated dot product of one axis with the position, saturated.
// ----------------------------------------------------------------------------
module evm_xlate import evm_pkg::*; (
    input  logic                     i_clk,
    input  t_axis                    i_a0,
    input  t_axis                    i_a1,
    input  t_axis                    i_a2,
    input  t_pos                     i_p0,
    input  t_pos                     i_p1,
    input  t_pos                     i_p2,
    output logic signed [SHIFT_W-1:0] o_shift
);
    localparam int PW = POS_W + AXIS_W;
    localparam int DW = POS_W + 18;
    localparam int RW = (POS_W + 4 > 33) ? POS_W + 4 : 33;
    localparam logic signed [RW-1:0] SMAX = RW'(64'sd2147483647);
    localparam logic signed [RW-1:0] SMIN = RW'(-64'sd2147483648);

    logic signed [PW-1:0]      r_m0, r_m1, r_m2;
    logic signed [DW-1:0]      nd;
    logic signed [RW-1:0]      rs;
    logic signed [SHIFT_W-1:0] r_shift;

    always_comb begin
        nd = DW'(14'sd0) + (DW'(8192) - (DW'(r_m0) + DW'(r_m1) + DW'(r_m2)));
        rs = RW'(nd >>> 14);
    end

    always_ff @(posedge i_clk) begin
        r_m0 <= i_a0 * i_p0;
        r_m1 <= i_a1 * i_p1;
        r_m2 <= i_a2 * i_p2;
        if (rs > SMAX) begin
            r_shift <= SMAX[SHIFT_W-1:0];
        end else if (rs < SMIN) begin
            r_shift <= SMIN[SHIFT_W-1:0];
        end else begin
            r_shift <= rs[SHIFT_W-1:0];
        end
    end

    assign o_shift = r_shift;

endmodule

[rtl/euler_yxz_view_matrix.sv]
// ----------------------------------------------------------------------------
// euler_yxz_view_matrix
// Rigid view transform (Y, X, Z rotation order) from a pose, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   signals                      transaction
//  command   i_start, o_busy, i_cmd       i_start high while o_busy low
//  result    o_done, o_result             one cycle with o_done high
//
//  One pose enters every cycle while reset is released; each result passes
//  through the stage chain: phase multiply 1, sine polynomial 4, axis
//  products 3, dot product and saturation 2.
//  o_busy is high only while reset is held; reset clears the valid chain only.
//  The receiver cannot stall, so no result is ever held back.
// ----------------------------------------------------------------------------
module euler_yxz_view_matrix import evm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    input  t_pose i_cmd,
    output logic  o_done,
    output t_view o_result
);
    localparam int PRW = ANGLE_W + 20;

    logic [LATENCY-1:0]       r_vld;
    logic [15:0]              r_ph [3];
    logic [15:0]              ph_cos [3];
    logic signed [PRW-1:0]    prod [3];
    t_sc                      s [3];
    t_sc                      c [3];
    t_axis                    ax [9];
    t_axis                    r_ax1 [9];
    t_axis                    r_ax2 [9];
    t_pos                     r_px [POS_DLY];
    t_pos                     r_py [POS_DLY];
    t_pos                     r_pz [POS_DLY];
    logic signed [SHIFT_W-1:0] sh [3];
    logic                     accept;

    // refuse transactions while reset is held
    assign o_busy = !i_rst_n;
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], accept};
        end
    end

    // phase order: yaw, pitch, roll
    always_comb begin
        prod[0] = PRW'(i_cmd.yaw_angle) * $signed({1'b0, TURN_SCALE}) + PRW'(32768);
        prod[1] = PRW'(i_cmd.pitch_angle) * $signed({1'b0, TURN_SCALE}) + PRW'(32768);
        prod[2] = PRW'(i_cmd.roll_angle) * $signed({1'b0, TURN_SCALE}) + PRW'(32768);
        for (int k = 0; k < 3; k++) begin
            ph_cos[k] = r_ph[k] + 16'h4000;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_ph[k] <= prod[k][31:16];
        end
        r_px[0] <= i_cmd.pos_x;
        r_py[0] <= i_cmd.pos_y;
        r_pz[0] <= i_cmd.pos_z;
        for (int k = 1; k < POS_DLY; k++) begin
            r_px[k] <= r_px[k-1];
            r_py[k] <= r_py[k-1];
            r_pz[k] <= r_pz[k-1];
        end
        r_ax1 <= ax;
        r_ax2 <= r_ax1;
    end

    for (genvar g = 0; g < 3; g++) begin : g_trig
        evm_sine u_sin (.i_clk(i_clk), .i_phase(r_ph[g]),   .o_sin(s[g]));
        evm_sine u_cos (.i_clk(i_clk), .i_phase(ph_cos[g]), .o_sin(c[g]));
    end

    evm_axes u_axes (
        .i_clk(i_clk),
        .i_s1(s[0]), .i_c1(c[0]),
        .i_s2(s[1]), .i_c2(c[1]),
        .i_s3(s[2]), .i_c3(c[2]),
        .o_ax(ax)
    );

    for (genvar g = 0; g < 3; g++) begin : g_xlate
        evm_xlate u_xlate (
            .i_clk(i_clk),
            .i_a0(ax[3*g]), .i_a1(ax[3*g+1]), .i_a2(ax[3*g+2]),
            .i_p0(r_px[POS_DLY-1]), .i_p1(r_py[POS_DLY-1]), .i_p2(r_pz[POS_DLY-1]),
            .o_shift(sh[g])
        );
    end

    assign o_done = r_vld[LATENCY-1];

    always_comb begin
        o_result.right_x       = r_ax2[0];
        o_result.right_y       = r_ax2[1];
        o_result.right_z       = r_ax2[2];
        o_result.upward_x      = r_ax2[3];
        o_result.upward_y      = r_ax2[4];
        o_result.upward_z      = r_ax2[5];
        o_result.forward_x     = r_ax2[6];
        o_result.forward_y     = r_ax2[7];
        o_result.forward_z     = r_ax2[8];
        o_result.shift_right   = sh[0];
        o_result.shift_upward  = sh[1];
        o_result.shift_forward = sh[2];
    end

endmodule

[rtl/evm_checker.sv]
// ----------------------------------------------------------------------------
// evm_checker
// Port-level checks on busy, latency and forward_y axis range, bound to the top level.
// ----------------------------------------------------------------------------
module evm_checker import evm_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_start,
    input logic  o_busy,
    input logic  o_done,
    input t_view o_result
);
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");

    a_done_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, LATENCY))
        else $error("result without transaction");

    a_cmd_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) ##LATENCY 1 |-> (o_done || !$past(i_rst_n, 1)))
        else $error("transaction lost");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.forward_y <= 16'sd16384 && o_result.forward_y >= -16'sd16384))
        else $error("axis out of range");
endmodule

bind euler_yxz_view_matrix evm_checker u_evm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
    .o_busy(o_busy), .o_done(o_done), .o_result(o_result)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Y-X-Z Euler view matrix. Poses are driven
// through the start/busy command port; each one is run through a behavioural
// fixed-point predictor and the resulting view is queued. Every o_done
// transaction is compared field by field with the oldest queued view.
// ----------------------------------------------------------------------------
module tb_top;
    import evm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    class view_scoreboard;
        t_view pending[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        static function longint floor_sh(longint v, int sh);
            return v >>> sh;
        endfunction

        static function longint clampl(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        static function bit [15:0] phase_of(logic signed [ANGLE_W-1:0] a);
            longint prod;
            prod = longint'(a) * 166886 + 32768;
            return prod[31:16];
        endfunction

        static function longint sine(bit [15:0] ph);
            longint q, z2, t, s;
            q = ph[13:0];
            if (ph[14]) q = 16384 - q;
            z2 = (q * q) >> 14;
            t  = 10512 - ((1160 * z2) >> 14);
            t  = 25736 - ((z2 * t) >> 14);
            s  = (q * t) >> 14;
            return ph[15] ? -s : s;
        endfunction

        static function longint cosine(bit [15:0] ph);
            return sine(ph + 16'h4000);
        endfunction

        static function longint axis(longint v42);
            return clampl(floor_sh(v42 + (64'sd1 <<< 27), 28), -16384, 16384);
        endfunction

        static function logic signed [31:0] shift_of(longint a0, longint a1, longint a2,
                                                     longint p0, longint p1, longint p2);
            longint d;
            d = a0 * p0 + a1 * p1 + a2 * p2;
            return 32'(clampl(floor_sh(-d + 8192, 14), -64'sd2147483648, 64'sd2147483647));
        endfunction

        // Predict the view of a pose and hold it until its result arrives
        function void note_pose(t_pose c);
            longint s1, c1, s2, c2, s3, c3, a[9], q;
            t_view v;
            q  = 16384;
            s1 = sine(phase_of(c.yaw_angle));   c1 = cosine(phase_of(c.yaw_angle));
            s2 = sine(phase_of(c.pitch_angle)); c2 = cosine(phase_of(c.pitch_angle));
            s3 = sine(phase_of(c.roll_angle));  c3 = cosine(phase_of(c.roll_angle));
            a[0] = axis(c1 * c3 * q + s1 * s2 * s3);
            a[1] = axis(c2 * s3 * q);
            a[2] = axis(c1 * s2 * s3 - c3 * s1 * q);
            a[3] = axis(c3 * s1 * s2 - c1 * s3 * q);
            a[4] = axis(c2 * c3 * q);
            a[5] = axis(c1 * c3 * s2 + s1 * s3 * q);
            a[6] = axis(c2 * s1 * q);
            a[7] = axis(-s2 * q * q);
            a[8] = axis(c1 * c2 * q);
            v.right_x   = 16'(a[0]); v.right_y   = 16'(a[1]); v.right_z   = 16'(a[2]);
            v.upward_x  = 16'(a[3]); v.upward_y  = 16'(a[4]); v.upward_z  = 16'(a[5]);
            v.forward_x = 16'(a[6]); v.forward_y = 16'(a[7]); v.forward_z = 16'(a[8]);
            v.shift_right   = shift_of(a[0], a[1], a[2], c.pos_x, c.pos_y, c.pos_z);
            v.shift_upward  = shift_of(a[3], a[4], a[5], c.pos_x, c.pos_y, c.pos_z);
            v.shift_forward = shift_of(a[6], a[7], a[8], c.pos_x, c.pos_y, c.pos_z);
            pending.push_back(v);
        endfunction

        function void cmp(string name, longint e, longint g);
            if (e != g) begin
                $error("%s: expected %0d, got %0d", name, e, g);
                errors++;
            end
        endfunction

        function void check_view(t_view g);
            t_view e;
            if (pending.size() == 0) begin
                $error("view arrived with no pose outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("right_x", e.right_x, g.right_x);
            cmp("right_y", e.right_y, g.right_y);
            cmp("right_z", e.right_z, g.right_z);
            cmp("upward_x", e.upward_x, g.upward_x);
            cmp("upward_y", e.upward_y, g.upward_y);
            cmp("upward_z", e.upward_z, g.upward_z);
            cmp("forward_x", e.forward_x, g.forward_x);
            cmp("forward_y", e.forward_y, g.forward_y);
            cmp("forward_z", e.forward_z, g.forward_z);
            cmp("shift_right", e.shift_right, g.shift_right);
            cmp("shift_upward", e.shift_upward, g.shift_upward);
            cmp("shift_forward", e.shift_forward, g.shift_forward);
        endfunction
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_start = 1'b0;
    logic  o_busy;
    t_pose i_cmd = '0;
    logic  o_done;
    t_view o_result;

    view_scoreboard views = new();
    int idle_pct = 0;

    euler_yxz_view_matrix DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_cmd(i_cmd), .o_done(o_done), .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) views.check_view(o_result);
    end

    // Offer one pose, with an optional random gap first; hold until accepted
    task automatic send_pose(t_pose c);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= c;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        views.note_pose(c);
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(3))
            0: return 16'($urandom_range(65535));
            1: return 16'(int'($urandom_range(25736)) - 12868);
            2: return 16'(int'($urandom_range(64)) * 1608 + int'($urandom_range(8)) - 4);
            default: return 16'(int'($urandom_range(32)) * 3217 / 2);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(2))
            0: return $urandom();
            1: return 32'(int'($urandom_range(2000000)) - 1000000);
            default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    task automatic send_directed();
        logic signed [15:0] ang[8];
        logic signed [31:0] pos[4];
        t_pose c;
        ang = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sd6434, -16'sd6434,
                16'sd3217, 16'sd12868, -16'sd1};
        pos = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh00010000};
        for (int k = 0; k < 24; k++) begin
            c.pitch_angle = ang[k % 8];
            c.yaw_angle   = ang[(k * 3 + 1) % 8];
            c.roll_angle  = ang[(k * 5 + 2) % 8];
            c.pos_x = pos[k % 4];
            c.pos_y = pos[(k + 1) % 4];
            c.pos_z = pos[(k / 4) % 4];
            send_pose(c);
        end
    endtask

    initial begin
        t_pose c;
        int pct[4];
        pct = '{0, 71, 0, 21};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_directed();
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = pct[ph];
            for (int n = 0; n < 290; n++) begin
                c.pitch_angle = rand_angle();
                c.yaw_angle   = rand_angle();
                c.roll_angle  = rand_angle();
                c.pos_x = rand_pos();
                c.pos_y = rand_pos();
                c.pos_z = rand_pos();
                send_pose(c);
            end
            // Drop i_start before the next phase
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b0;
        while (views.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (views.errors == 0)
            $display("euler_yxz_view_matrix: match");
        else
            $display("euler_yxz_view_matrix: mismatch");
        $finish;
    end

    initial begin
        #2ms;
        $display("euler_yxz_view_matrix: mismatch");
        $finish;
    end
endmodule
